// File: rtl/core/bosp_pkg.sv
package bosp_pkg;

    // Fixed widths of the slot-age store and the strength divider.
    localparam int AGE_W = 16;
    localparam int QUO_W = 14;
    localparam int CFG_ADDR_W = 5;

    localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;
    localparam logic [7:0] FRAMES_MAX = 8'd255;
    localparam logic [14:0] BASE_STRENGTH = 15'd5734;
    localparam logic [14:0] FULL_STRENGTH = 15'd18022;
    localparam logic [15:0] HUE_STEP = 16'd11141;
    localparam logic [15:0] POP_BIAS_Q16 = 16'd1311;

    localparam logic [15:0] FIRE_RATIO_RST = 16'd5530;
    localparam logic [15:0] FIRE_OFFSET_RST = 16'd1311;
    localparam logic [15:0] REARM_RATIO_RST = 16'd5120;
    localparam logic [15:0] REARM_OFFSET_RST = 16'd655;
    localparam logic [15:0] TROUGH_RISE_RST = 16'd695;
    localparam logic [7:0] REFRACTORY_RST = 8'd9;

    typedef enum logic [2:0] {
        REG_FIRE_RATIO   = 3'd0,
        REG_FIRE_OFFSET  = 3'd1,
        REG_REARM_RATIO  = 3'd2,
        REG_REARM_OFFSET = 3'd3,
        REG_TROUGH_RISE  = 3'd4,
        REG_REFRACTORY   = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_RISE,
        S_UPD,
        S_MUL_FIRE,
        S_MUL_REARM,
        S_DECIDE,
        S_DIV,
        S_WAIT
    } t_state;

    // Commands from the detector sequencer to the slot pool.
    typedef struct packed {
        logic start;
        logic grant;
    } t_pool_cmd;

endpackage

// File: rtl/core/bosp_ram.sv
module bosp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bosp_div.sv
module bosp_div #(
    parameter int DEN_W = 17,
    parameter int QUO_W = 14,
    localparam int W  = DEN_W + QUO_W,
    localparam int CW = (QUO_W > 1) ? $clog2(QUO_W) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    // Restoring division, one quotient bit per cycle, MSB first. The caller
    // guarantees that the quotient fits in QUO_W bits.
    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic             w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QUO_W - 1);
                r_rem  <= i_num;
                r_dsh  <= W'(i_den) << (QUO_W - 1);
                r_quo  <= '0;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/core/bosp_slot_pool.sv
module bosp_slot_pool import bosp_pkg::*; #(
    parameter int NUM_SLOTS = 8,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pool_cmd         i_cmd,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_best
);

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(NUM_SLOTS - 1);

    // A sweep reads every age, ages it by one frame and writes it back while
    // tracking the oldest entry seen so far. A grant afterwards writes the
    // chosen entry as one frame old. Entries never written read as saturated.
    logic                 r_sweep;
    logic [SLOT_W-1:0]    r_rd_idx;
    logic                 r_pend;
    logic [SLOT_W-1:0]    r_pend_idx;
    logic [SLOT_W-1:0]    r_best;
    logic [AGE_W-1:0]     r_best_age;
    logic                 r_done;
    logic [NUM_SLOTS-1:0] r_valid;

    logic [AGE_W-1:0]  w_rd_data;
    logic [AGE_W-1:0]  w_age;
    logic [AGE_W-1:0]  w_inc;
    logic              w_wr_en;
    logic [SLOT_W-1:0] w_wr_addr;
    logic [AGE_W-1:0]  w_wr_data;

    assign w_age = r_valid[r_pend_idx] ? w_rd_data : AGE_MAX;
    assign w_inc = (w_age == AGE_MAX) ? w_age : w_age + AGE_W'(1);

    assign w_wr_en   = r_pend | i_cmd.grant;
    assign w_wr_addr = r_pend ? r_pend_idx : r_best;
    assign w_wr_data = r_pend ? w_inc : AGE_W'(1);

    bosp_ram #(
        .WIDTH (AGE_W),
        .DEPTH (NUM_SLOTS)
    ) u_age_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (r_sweep),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_valid <= '0;
        end else begin
            if (i_cmd.start) begin
                r_sweep  <= 1'b1;
                r_rd_idx <= '0;
                r_done   <= 1'b0;
            end else if (r_sweep) begin
                if (r_rd_idx == LAST) begin
                    r_sweep <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + SLOT_W'(1);
                end
            end
            r_pend     <= r_sweep;
            r_pend_idx <= r_rd_idx;
            if (r_pend) begin
                if (r_pend_idx == '0 || w_age > r_best_age) begin
                    r_best     <= r_pend_idx;
                    r_best_age <= w_age;
                end
                if (r_pend_idx == LAST) begin
                    r_done <= 1'b1;
                end
                r_valid[r_pend_idx] <= 1'b1;
            end
            if (i_cmd.grant) begin
                r_valid[r_best] <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_best = r_best;

endmodule

// File: rtl/core/beat_onset_detector_slot_pool.sv
// Beat onset detector with a pool of ring slots.
// The input channel (i_valid, o_stall, i_bass_level) takes one bass-envelope
// sample per display frame. Each accepted sample produces exactly one result
// transfer on the output channel (o_valid, i_stall, o_beat, o_slot_index,
// o_ring_strength, o_hue_phase); when no beat fires, only o_beat is low and
// the other fields are zero.
// The result waits for the slot-age sweep through the age memory, and when a
// beat fires with a ring strength between base and full, it goes through
// the 14-step divider first. One sample is processed at a time; o_stall is
// high while a sample is in process.
// A finished result sits in an output register; the next sample is accepted
// while it waits. If the receiver keeps i_stall high, the following result
// waits in the sequencer until the output register frees up.
// A synchronous reset (i_rst_n low) restores the configuration defaults,
// clears the trough, arms the detector, saturates the frame counter and
// marks every slot as oldest. There is no clearing pass.
// The user must write configuration through the APB port only while the
// block is idle; the block itself does not enforce this.
module beat_onset_detector_slot_pool import bosp_pkg::*; #(
    parameter int NUM_SLOTS  = 8,
    parameter int LEVEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_bass_level,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_beat,
    output logic [2:0]            o_slot_index,
    output logic [14:0]           o_ring_strength,
    output logic [15:0]           o_hue_phase,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int LB     = LEVEL_BITS;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FW     = LB + 17;   // threshold compare width
    localparam int DW     = LB + 1;    // strength denominator width
    localparam int SW     = LB + 4;    // saturation compare width
    localparam int NW     = DW + QUO_W;

    // ---------------- Configuration registers ----------------
    logic [15:0] r_fire_ratio;
    logic [15:0] r_fire_offset;
    logic [15:0] r_rearm_ratio;
    logic [15:0] r_rearm_offset;
    logic [15:0] r_trough_rise;
    logic [7:0]  r_refractory;
    logic        w_cfg_wr;
    t_reg_idx    w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire_ratio   <= FIRE_RATIO_RST;
            r_fire_offset  <= FIRE_OFFSET_RST;
            r_rearm_ratio  <= REARM_RATIO_RST;
            r_rearm_offset <= REARM_OFFSET_RST;
            r_trough_rise  <= TROUGH_RISE_RST;
            r_refractory   <= REFRACTORY_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_FIRE_RATIO:   r_fire_ratio   <= pwdata[15:0];
                REG_FIRE_OFFSET:  r_fire_offset  <= pwdata[15:0];
                REG_REARM_RATIO:  r_rearm_ratio  <= pwdata[15:0];
                REG_REARM_OFFSET: r_rearm_offset <= pwdata[15:0];
                REG_TROUGH_RISE:  r_trough_rise  <= pwdata[15:0];
                REG_REFRACTORY:   r_refractory   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_FIRE_RATIO:   prdata = {16'd0, r_fire_ratio};
            REG_FIRE_OFFSET:  prdata = {16'd0, r_fire_offset};
            REG_REARM_RATIO:  prdata = {16'd0, r_rearm_ratio};
            REG_REARM_OFFSET: prdata = {16'd0, r_rearm_offset};
            REG_TROUGH_RISE:  prdata = {16'd0, r_trough_rise};
            REG_REFRACTORY:   prdata = {24'd0, r_refractory};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- Detector state ----------------
    t_state          r_state, n_state;
    logic [LB-1:0]   r_bass, n_bass;
    logic [LB-1:0]   r_trough, n_trough;
    logic            r_armed, n_armed;
    logic [7:0]      r_frames, n_frames;
    logic [15:0]     r_color, n_color;
    logic [LB+15:0]  r_prod, n_prod;
    logic            r_fire, n_fire;
    logic            r_beat, n_beat;
    logic [14:0]     r_strength, n_strength;

    logic            r_out_valid, n_out_valid;
    logic            r_out_beat, n_out_beat;
    logic [2:0]      r_out_slot, n_out_slot;
    logic [14:0]     r_out_strength, n_out_strength;
    logic [15:0]     r_out_hue, n_out_hue;

    // The level format may be wider or narrower than the 16-bit sample port.
    logic [LB+15:0] w_bass_ext;
    logic [LB-1:0]  w_bass;
    assign w_bass_ext = {{LB{1'b0}}, i_bass_level};
    assign w_bass     = w_bass_ext[LB-1:0];

    // Q0.16 offsets rescaled into the level format.
    logic [LB+15:0] w_fire_off_sh, w_rearm_off_sh, w_bias_sh;
    logic [LB-1:0]  w_fire_lvl, w_rearm_lvl, w_bias_lvl;
    assign w_fire_off_sh  = {r_fire_offset, {LB{1'b0}}};
    assign w_rearm_off_sh = {r_rearm_offset, {LB{1'b0}}};
    assign w_bias_sh      = {POP_BIAS_Q16, {LB{1'b0}}};
    assign w_fire_lvl     = w_fire_off_sh[LB+15:16];
    assign w_rearm_lvl    = w_rearm_off_sh[LB+15:16];
    assign w_bias_lvl     = w_bias_sh[LB+15:16];

    // One multiplier, shared over three sequencer steps.
    logic [LB-1:0]  w_mul_a;
    logic [15:0]    w_mul_b;
    logic [LB+15:0] w_prod;
    assign w_prod = (LB + 16)'(w_mul_a) * (LB + 16)'(w_mul_b);

    // Threshold compares, exact in the scaled-by-4096 domain.
    logic [FW-1:0] w_bass_sh;
    logic          w_fire_hit, w_rearm_hit;
    assign w_bass_sh   = FW'(r_bass) << 12;
    assign w_fire_hit  = w_bass_sh > (FW'(r_prod) + (FW'(w_fire_lvl) << 12));
    assign w_rearm_hit = w_bass_sh < (FW'(r_prod) + (FW'(w_rearm_lvl) << 12));

    // Strength: punch ratio (bass - D) / D with D = trough + 0.02.
    logic [DW-1:0] w_d, w_diff;
    logic [SW-1:0] w_diff5, w_d6;
    logic [NW-1:0] w_num;
    logic          w_le_d, w_sat;
    assign w_d     = DW'(r_trough) + DW'(w_bias_lvl);
    assign w_diff  = DW'(r_bass) - w_d;
    assign w_le_d  = DW'(r_bass) <= w_d;
    assign w_diff5 = (SW'(w_diff) << 2) + SW'(w_diff);
    assign w_d6    = (SW'(w_d) << 2) + (SW'(w_d) << 1);
    assign w_sat   = w_diff5 >= w_d6;
    assign w_num   = (NW'(w_diff) << 13) + (NW'(w_diff) << 11);

    logic             w_div_start;
    logic             w_div_done;
    logic [QUO_W-1:0] w_div_quo;

    bosp_div #(
        .DEN_W (DW),
        .QUO_W (QUO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_d),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    t_pool_cmd         w_pool_cmd;
    logic              w_pool_done;
    logic [SLOT_W-1:0] w_pool_best;
    logic [SLOT_W+2:0] w_slot_ext;

    bosp_slot_pool #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_pool_cmd),
        .o_done  (w_pool_done),
        .o_best  (w_pool_best)
    );

    assign w_slot_ext = {3'b000, w_pool_best};

    // ---------------- Sequencer ----------------
    always_comb begin
        n_state        = r_state;
        n_bass         = r_bass;
        n_trough       = r_trough;
        n_armed        = r_armed;
        n_frames       = r_frames;
        n_color        = r_color;
        n_prod         = r_prod;
        n_fire         = r_fire;
        n_beat         = r_beat;
        n_strength     = r_strength;
        n_out_valid    = r_out_valid & i_stall;
        n_out_beat     = r_out_beat;
        n_out_slot     = r_out_slot;
        n_out_strength = r_out_strength;
        n_out_hue      = r_out_hue;
        w_mul_a        = '0;
        w_mul_b        = '0;
        w_div_start    = 1'b0;
        w_pool_cmd     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bass           = w_bass;
                    w_pool_cmd.start = 1'b1;
                    n_state          = S_MUL_RISE;
                end
            end
            S_MUL_RISE: begin
                w_mul_a = r_bass - r_trough;
                w_mul_b = r_trough_rise;
                n_prod  = w_prod;
                n_state = S_UPD;
            end
            S_UPD: begin
                // The follower snaps down to a dip, else rises part of the way.
                if (r_bass < r_trough) begin
                    n_trough = r_bass;
                end else begin
                    n_trough = r_trough + r_prod[LB+15:16];
                end
                n_state = S_MUL_FIRE;
            end
            S_MUL_FIRE: begin
                w_mul_a = r_trough;
                w_mul_b = r_fire_ratio;
                n_prod  = w_prod;
                n_state = S_MUL_REARM;
            end
            S_MUL_REARM: begin
                n_fire  = r_armed && w_fire_hit && (r_frames > r_refractory);
                w_mul_a = r_trough;
                w_mul_b = r_rearm_ratio;
                n_prod  = w_prod;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_beat     = r_fire;
                n_strength = '0;
                n_state    = S_WAIT;
                if (r_fire) begin
                    // Frame and slot ages restart at zero and then age by one.
                    n_armed  = 1'b0;
                    n_frames = 8'd1;
                    n_color  = r_color + HUE_STEP;
                    if (w_le_d) begin
                        n_strength = BASE_STRENGTH;
                    end else if (w_sat) begin
                        n_strength = FULL_STRENGTH;
                    end else begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end else begin
                    if (!r_armed && w_rearm_hit) begin
                        n_armed = 1'b1;
                    end
                    if (r_frames != FRAMES_MAX) begin
                        n_frames = r_frames + 8'd1;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_strength = BASE_STRENGTH + 15'(w_div_quo);
                    n_state    = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_pool_done && (!r_out_valid || !i_stall)) begin
                    n_out_valid      = 1'b1;
                    n_out_beat       = r_beat;
                    n_out_slot       = r_beat ? w_slot_ext[2:0] : 3'd0;
                    n_out_strength   = r_strength;
                    n_out_hue        = r_beat ? r_color : 16'd0;
                    w_pool_cmd.grant = r_beat;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_trough    <= '0;
            r_armed     <= 1'b1;
            r_frames    <= FRAMES_MAX;
            r_color     <= '0;
            r_fire      <= 1'b0;
            r_beat      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_trough    <= n_trough;
            r_armed     <= n_armed;
            r_frames    <= n_frames;
            r_color     <= n_color;
            r_fire      <= n_fire;
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bass         <= n_bass;
        r_prod         <= n_prod;
        r_strength     <= n_strength;
        r_out_beat     <= n_out_beat;
        r_out_slot     <= n_out_slot;
        r_out_strength <= n_out_strength;
        r_out_hue      <= n_out_hue;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_beat          = r_out_beat;
    assign o_slot_index    = r_out_slot;
    assign o_ring_strength = r_out_strength;
    assign o_hue_phase     = r_out_hue;

    // ---------------- Assertions ----------------
    // A delivered beat carries a strength between the base and the full value.
    a_strength_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat) |->
        (o_ring_strength >= BASE_STRENGTH && o_ring_strength <= FULL_STRENGTH))
        else $error("beat strength out of range");

    // Without a beat the slot, strength and hue fields are zero.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_beat) |->
        (o_slot_index == 3'd0 && o_ring_strength == 15'd0 && o_hue_phase == 16'd0))
        else $error("non-beat result carries payload");

    // A firing decision disarms the detector and restarts the frame count.
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_fire) |=> (!r_armed && r_frames == 8'd1))
        else $error("beat did not disarm detector");

    // A result is only loaded once the slot sweep has finished.
    a_sweep_before_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && n_state == S_IDLE) |-> (w_pool_done && !o_stall == 1'b0))
        else $error("result loaded before slot sweep finished");

endmodule

// File: verif/testbench.sv
module testbench;
    import bosp_pkg::*;

    // Constants of the detector, kept apart from the RTL so that the
    // prediction stands on its own.
    localparam int RING_SLOTS     = 8;
    localparam int BASE_RING      = 5734;
    localparam int FULL_RING      = 18022;
    localparam int HUE_INC        = 11141;
    localparam int PUNCH_BIAS     = 1311;
    localparam int NUM_REGS       = 6;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 40;
    localparam int NUM_PHASES     = 6;

    // One frame result as it leaves the block.
    typedef struct packed {
        logic        beat;
        logic [2:0]  slot;
        logic [14:0] strength;
        logic [15:0] hue;
    } frame_t;

    // The scoreboard keeps its own copy of the detector: the trough
    // follower, the arming flag, the frame counter, the color phase and
    // the age of every ring slot. Each accepted sample is run through it
    // and the frame it produces waits in a queue until the block's own
    // frame shows up.
    class onset_scoreboard;
        logic [15:0] pop_gain, pop_bias, rearm_gain, rearm_bias, rise_coef;
        logic [7:0]  holdoff_frames;
        logic [15:0] floor_level;
        bit          primed;
        logic [7:0]  frames_idle;
        logic [15:0] palette_pos;
        logic [15:0] age [RING_SLOTS];
        frame_t      frames_due [$];
        int          errors;

        function void clear();
            pop_gain       = 16'd5530;
            pop_bias       = 16'd1311;
            rearm_gain     = 16'd5120;
            rearm_bias     = 16'd655;
            rise_coef      = 16'd695;
            holdoff_frames = 8'd9;
            floor_level    = '0;
            primed         = 1'b1;
            frames_idle    = 8'hFF;
            palette_pos    = '0;
            foreach (age[i]) age[i] = 16'hFFFF;
            frames_due.delete();
            errors = 0;
        endfunction

        // Only the low bits of each register are kept; unknown indexes
        // are dropped.
        function void set_reg(int idx, logic [31:0] data);
            case (idx)
                REG_FIRE_RATIO:   pop_gain = data[15:0];
                REG_FIRE_OFFSET:  pop_bias = data[15:0];
                REG_REARM_RATIO:  rearm_gain = data[15:0];
                REG_REARM_OFFSET: rearm_bias = data[15:0];
                REG_TROUGH_RISE:  rise_coef = data[15:0];
                REG_REFRACTORY:   holdoff_frames = data[7:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic [15:0] lvl);
            bit [31:0] prod;
            bit [63:0] lhs, fire_rhs, rearm_rhs, d, diff;
            int pick;
            frame_t r;
            r = '0;
            // The trough snaps down on a dip, else creeps up by a rise_coef share of the gap.
            if (lvl < floor_level) begin
                floor_level = lvl;
            end else begin
                prod = rise_coef * (lvl - floor_level);
                floor_level = floor_level + prod[31:16];
            end
            lhs = 64'(lvl) << 12;
            fire_rhs = 64'(floor_level) * 64'(pop_gain) + (64'(pop_bias) << 12);
            rearm_rhs = 64'(floor_level) * 64'(rearm_gain) + (64'(rearm_bias) << 12);
            if (primed && lhs > fire_rhs && frames_idle > holdoff_frames) begin
                pick = 0;
                for (int i = 1; i < RING_SLOTS; i++)
                    if (age[i] > age[pick]) pick = i;
                palette_pos = palette_pos + 16'(HUE_INC);
                age[pick] = '0;
                frames_idle = '0;
                primed = 1'b0;
                r.beat = 1'b1;
                r.slot = pick[2:0];
                r.hue = palette_pos;
                d = 64'(floor_level) + PUNCH_BIAS;
                if (64'(lvl) <= d) begin
                    r.strength = 15'(BASE_RING);
                end else begin
                    diff = 64'(lvl) - d;
                    if (5 * diff >= 6 * d)
                        r.strength = 15'(FULL_RING);
                    else
                        r.strength = 15'(BASE_RING + (diff * 10240) / d);
                end
            end else if (!primed && lhs < rearm_rhs) begin
                primed = 1'b1;
            end
            if (frames_idle != 8'hFF) frames_idle++;
            foreach (age[i])
                if (age[i] != 16'hFFFF) age[i]++;
            frames_due.push_back(r);
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame result, actual beat %0d slot %0d", $time,
                         got.beat, got.slot);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            compare_field("beat", want.beat, got.beat);
            compare_field("slot_index", want.slot, got.slot);
            compare_field("ring_strength", want.strength, got.strength);
            compare_field("hue_phase", want.hue, got.hue);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [15:0]           i_bass_level = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_beat;
    logic [2:0]            o_slot_index;
    logic [14:0]           o_ring_strength;
    logic [15:0]           o_hue_phase;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    onset_scoreboard sb = new;

    // Idle rates of the two sides, in percent, changed from phase to phase.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    // The refractory setting in force, used to shape the quiet stretches.
    int holdoff_now = 9;
    logic [15:0] opening [25];

    beat_onset_detector_slot_pool u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_bass_level   (i_bass_level),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_beat         (o_beat),
        .o_slot_index   (o_slot_index),
        .o_ring_strength(o_ring_strength),
        .o_hue_phase    (o_hue_phase),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both channels are watched at the clock edge, where the values seen
    // are the ones the block itself samples. Every input transfer feeds the
    // prediction and every output transfer is checked against it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.take_sample(i_bass_level);
            if (o_valid && !i_stall)
                sb.check_frame('{o_beat, o_slot_index, o_ring_strength, o_hue_phase});
        end
    end

    // The receiver. It stalls at the rate of the current phase, and once,
    // after a few dozen transfers, it holds off for a long stretch while the
    // sender keeps offering samples. The block then has a frame in its output
    // register and one more in its sequencer, and has to stall its input.
    initial begin
        int taken;
        int hold_left;
        bit held;
        taken = 0;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) taken++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    // A register write: setup cycle, then access cycle. The lines drop for
    // one cycle afterwards so that back-to-back writes never lower and raise
    // psel in the same step.
    task automatic reg_write(input int idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx * 4);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Writes all six registers. The bits above each register's width carry
    // random junk, which the block has to drop.
    task automatic apply_setting(input logic [15:0] fr, input logic [15:0] fo,
                                 input logic [15:0] rr, input logic [15:0] ro,
                                 input logic [15:0] tr, input logic [7:0] rf);
        reg_write(REG_FIRE_RATIO, {16'($urandom), fr});
        reg_write(REG_FIRE_OFFSET, {16'($urandom), fo});
        reg_write(REG_REARM_RATIO, {16'($urandom), rr});
        reg_write(REG_REARM_OFFSET, {16'($urandom), ro});
        reg_write(REG_TROUGH_RISE, {16'($urandom), tr});
        reg_write(REG_REFRACTORY, {24'($urandom), rf});
        holdoff_now = rf;
    endtask

    // Offers one sample and returns at the edge where it is taken. A sender
    // gap, if any, comes before the sample; valid stays high from one sample
    // to the next when there is none.
    task automatic send_level(input logic [15:0] lvl);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_bass_level <= lvl;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Waits until every predicted frame has come back, then lets the block
    // settle for longer than its slowest sample takes.
    task automatic drain_results();
        @(posedge i_clk);
        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int left;
        int run;
        int phase_len;
        sb.clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values written back with junk in the upper data bits.
        apply_setting(16'd5530, 16'd1311, 16'd5120, 16'd655, 16'd695, 8'd9);

        // Opening sequence: a full-scale pop right after reset (saturated
        // strength, first of equally old slots), a dip that re-arms, a pop
        // inside the refractory window, a quiet stretch and a moderate pop
        // for a strength between the limits, a repeat while disarmed, the
        // smallest nonzero sample, alternating bit patterns, and a final
        // full-scale pop after another quiet stretch.
        opening = '{16'hFFFF, 16'h0000, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'd2000, 16'd2000, 16'h0001, 16'h0000, 16'h5555, 16'hAAAA, 16'h8000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'hFFFF};
        foreach (opening[i]) send_level(opening[i]);
        i_valid <= 1'b0;
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_len = 140;
            case (p)
                0: phase_len = 150;
                1: begin
                    // Lowest fire ratio and offset, highest re-arm ratio and offset, fastest
                    // trough, no refractory time: nearly every rising sample fires with base strength.
                    apply_setting(16'd4096, 16'd0, 16'd65535, 16'd65535, 16'd65535, 8'd0);
                    phase_len = 150;
                end
                2: begin
                    // Highest fire thresholds, lowest re-arm thresholds, frozen trough, longest refractory time.
                    apply_setting(16'd65535, 16'd65535, 16'd4096, 16'd0, 16'd0, 8'd255);
                    phase_len = 40;
                end
                3: begin
                    // Writes past the last register must change nothing.
                    reg_write(NUM_REGS, $urandom);
                    reg_write(NUM_REGS + 1, $urandom);
                    apply_setting(16'($urandom_range(4096, 7000)), 16'($urandom_range(0, 3000)),
                                  16'($urandom_range(4096, 6000)), 16'($urandom_range(0, 2000)),
                                  16'($urandom), 8'($urandom_range(0, 15)));
                end
                default: begin
                    apply_setting(16'($urandom_range(4096, 7000)), 16'($urandom_range(0, 3000)),
                                  16'($urandom_range(4096, 6000)), 16'($urandom_range(0, 2000)),
                                  16'($urandom), 8'($urandom_range(0, 15)));
                    phase_len = (p == NUM_PHASES - 1) ? 130 : 140;
                end
            endcase

            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase

            // Mostly beat patterns: a quiet stretch around the refractory
            // length followed by a pop. The rest is full-range noise.
            left = phase_len;
            while (left > 0) begin
                if ($urandom_range(99) < 20) begin
                    send_level(16'($urandom));
                    left--;
                end else begin
                    run = $urandom_range(0, holdoff_now + 4);
                    for (int k = 0; k < run && left > 1; k++) begin
                        send_level(16'($urandom_range(0, 2500)));
                        left--;
                    end
                    send_level(16'($urandom_range(3000, 65535)));
                    left--;
                end
            end
            i_valid <= 1'b0;
            drain_results();
        end

        if (sb.errors == 0 && sb.frames_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("%0t: timeout with %0d frames outstanding", $time, sb.frames_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: beat_onset_detector_slot_pool.f
rtl/core/bosp_pkg.sv
rtl/core/bosp_ram.sv
rtl/core/bosp_div.sv
rtl/core/bosp_slot_pool.sv
rtl/core/beat_onset_detector_slot_pool.sv
verif/testbench.sv
